@@ hdl/rdfs_mc_pkg.sv @@
// Shared types, codes and helpers for the depth-first maze carver.
`default_nettype none
package rdfs_mc_pkg;

	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 6'd32;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] KIND_STARTED = 2'd0;
	localparam logic [1:0] KIND_CARVED  = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_WALL    = 2'd3;

	localparam logic [1:0] DIR_TOP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT  = 2'd1;
	localparam logic [1:0] DIR_BOTTOM = 2'd2;
	localparam logic [1:0] DIR_LEFT   = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] random_word;
		logic [4:0]  query_row;
		logic [4:0]  query_col;
		logic [1:0]  query_dir;
	} request_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [4:0] cell_row;
		logic [4:0] cell_col;
		logic [1:0] carved_dir;
		logic       wall_present;
	} result_t;

	// One cell of the maze: visited flag plus walls (bit0 top ... bit3 left).
	typedef struct packed {
		logic       visited;
		logic [3:0] walls;
	} cell_entry_t;

	localparam int CELL_W = 5;

	function automatic logic [3:0] dir_mask(input logic [1:0] d);
		return 4'b0001 << d;
	endfunction

	function automatic logic [1:0] dir_opposite(input logic [1:0] d);
		return d + 2'd2;
	endfunction

endpackage
`default_nettype wire

@@ hdl/rdfs_mc_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module rdfs_mc_ram #(
	parameter int WIDTH  = 5,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/rdfs_mc_nbr_unit.sv @@
// Neighbor address unit: coordinates of the cell beside the current one and its bounds check.
`default_nettype none
module rdfs_mc_nbr_unit
	import rdfs_mc_pkg::*;
#(
	parameter int ROW_W  = 5,
	parameter int COL_W  = 5,
	parameter int RDIM_W = 6,
	parameter int CDIM_W = 6
) (
	input  wire logic [ROW_W-1:0]  cur_row,
	input  wire logic [COL_W-1:0]  cur_col,
	input  wire logic [1:0]        dir,
	input  wire logic [RDIM_W-1:0] gen_rows,
	input  wire logic [CDIM_W-1:0] gen_cols,
	output logic                   nb_ok,
	output logic      [ROW_W-1:0]  nb_row,
	output logic      [COL_W-1:0]  nb_col
);

	logic [RDIM_W:0] row_next;
	logic [CDIM_W:0] col_next;

	assign row_next = (RDIM_W+1)'(cur_row) + 1'b1;
	assign col_next = (CDIM_W+1)'(cur_col) + 1'b1;

	always_comb begin
		nb_ok  = 1'b0;
		nb_row = cur_row;
		nb_col = cur_col;
		case (dir)
			DIR_TOP: begin
				nb_ok  = (cur_row != '0);
				nb_row = cur_row - 1'b1;
			end
			DIR_RIGHT: begin
				nb_ok  = (col_next < {1'b0, gen_cols});
				nb_col = cur_col + 1'b1;
			end
			DIR_BOTTOM: begin
				nb_ok  = (row_next < {1'b0, gen_rows});
				nb_row = cur_row + 1'b1;
			end
			DIR_LEFT: begin
				nb_ok  = (cur_col != '0);
				nb_col = cur_col - 1'b1;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/random_dfs_maze_carver_unit.sv @@
// Top level: command sequencer of the randomized depth-first maze carver.
// Busy is high until the result strobe, so the next request can be accepted on the edge that takes
// the result. The receiver cannot stall.
// Start: a clearing pass writes every cell of the cell RAM.
// Step: a carve takes a stack read, five cell reads over the single cell RAM read port and two cell
// writes, plus a stack read and five cell reads for each dead-end cell popped; an empty stack answers done.
// Query: read from the cell RAM only when the maze can be read; a zero-sized start skips the clearing pass.
// Reset clears control state only; cell contents are rebuilt by the next start.
`default_nettype none
module random_dfs_maze_carver_unit
	import rdfs_mc_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire request_t              request,
	output logic                       result_valid,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int SDEP_W = ADDR_W + 1;
	localparam int NCELLS = MAX_ROWS * MAX_COLS;
	localparam int RDIM_W = ($clog2(MAX_ROWS + 1) > CFG_DATA_W) ? $clog2(MAX_ROWS + 1) : CFG_DATA_W;
	localparam int CDIM_W = ($clog2(MAX_COLS + 1) > CFG_DATA_W) ? $clog2(MAX_COLS + 1) : CFG_DATA_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CLEAR  = 4'd1;
	localparam logic [3:0] ST_POP_RD = 4'd2;
	localparam logic [3:0] ST_POP_WT = 4'd3;
	localparam logic [3:0] ST_NB     = 4'd4;
	localparam logic [3:0] ST_PICK   = 4'd5;
	localparam logic [3:0] ST_WR_CUR = 4'd6;
	localparam logic [3:0] ST_WR_NX  = 4'd7;
	localparam logic [3:0] ST_QRY_WT = 4'd8;

	localparam logic [2:0] NB_CUR  = 3'd4;
	localparam logic [2:0] NB_LAST = 3'd5;

	logic [3:0]            state_q;
	logic [CFG_DATA_W-1:0] maze_rows_q;
	logic [CFG_DATA_W-1:0] maze_cols_q;
	logic [RDIM_W-1:0]     gen_rows_q;
	logic [CDIM_W-1:0]     gen_cols_q;
	logic [SDEP_W-1:0]     depth_q;
	logic                  ready_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [2:0]            nb_idx_q;
	logic [ROW_W-1:0]      cur_row_q;
	logic [COL_W-1:0]      cur_col_q;
	logic [31:0]           rnd_q;
	logic [1:0]            qdir_q;
	logic [3:0]            inrange_q;
	cell_entry_t           ent_q [5];
	logic [1:0]            d_q;
	logic [3:0]            nx_walls_q;
	result_t               res_q;
	logic                  res_valid_q;

	logic [RDIM_W-1:0] eff_rows;
	logic [CDIM_W-1:0] eff_cols;
	logic              accept;
	logic              query_ok;
	logic [ROW_W-1:0]  q_row;
	logic [COL_W-1:0]  q_col;

	logic              nb_ok;
	logic [ROW_W-1:0]  nb_row;
	logic [COL_W-1:0]  nb_col;
	logic [1:0]        nb_dir;

	logic              cram_we;
	logic [ADDR_W-1:0] cram_waddr;
	logic [ADDR_W-1:0] cram_raddr;
	cell_entry_t       cram_wdata;
	logic [CELL_W-1:0] cram_rdata;
	cell_entry_t       cram_rent;

	logic              sram_we;
	logic [ADDR_W-1:0] sram_waddr;
	logic [ADDR_W-1:0] sram_wdata;
	logic [ADDR_W-1:0] sram_raddr;
	logic [ADDR_W-1:0] sram_rdata;
	logic [SDEP_W-1:0] depth_m1;

	logic [3:0]        cand;
	logic [2:0]        cand_cnt;
	logic [34:0]       prod;
	logic [1:0]        pick_k;
	logic [1:0]        sel_dir;
	logic [2:0]        seen;
	logic [RDIM_W-1:0] row_ext;
	logic [CDIM_W-1:0] col_ext;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign cram_rent    = cell_entry_t'(cram_rdata);

	assign eff_rows = (RDIM_W'(maze_rows_q) > RDIM_W'(MAX_ROWS)) ? RDIM_W'(MAX_ROWS)
	                                                            : RDIM_W'(maze_rows_q);
	assign eff_cols = (CDIM_W'(maze_cols_q) > CDIM_W'(MAX_COLS)) ? CDIM_W'(MAX_COLS)
	                                                            : CDIM_W'(maze_cols_q);

	// A wall is read only from a finished maze whose row count still matches the register.
	assign query_ok = ready_q && (gen_cols_q != '0) && (gen_rows_q == eff_rows)
	                  && (RDIM_W'(request.query_row) < gen_rows_q)
	                  && (CDIM_W'(request.query_col) < gen_cols_q);
	assign q_row = ROW_W'(request.query_row);
	assign q_col = COL_W'(request.query_col);

	assign nb_dir   = (state_q == ST_NB) ? nb_idx_q[1:0] : d_q;
	assign depth_m1 = depth_q - 1'b1;
	assign row_ext  = RDIM_W'(cur_row_q);
	assign col_ext  = CDIM_W'(cur_col_q);

	rdfs_mc_nbr_unit #(
		.ROW_W  (ROW_W),
		.COL_W  (COL_W),
		.RDIM_W (RDIM_W),
		.CDIM_W (CDIM_W)
	) u_nbr (
		.cur_row  (cur_row_q),
		.cur_col  (cur_col_q),
		.dir      (nb_dir),
		.gen_rows (gen_rows_q),
		.gen_cols (gen_cols_q),
		.nb_ok    (nb_ok),
		.nb_row   (nb_row),
		.nb_col   (nb_col)
	);

	rdfs_mc_ram #(
		.WIDTH  (CELL_W),
		.ADDR_W (ADDR_W)
	) u_cell_ram (
		.clk   (clk),
		.we    (cram_we),
		.waddr (cram_waddr),
		.wdata (cram_wdata),
		.raddr (cram_raddr),
		.rdata (cram_rdata)
	);

	rdfs_mc_ram #(
		.WIDTH  (ADDR_W),
		.ADDR_W (ADDR_W)
	) u_stack_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (sram_wdata),
		.raddr (sram_raddr),
		.rdata (sram_rdata)
	);

	always_comb begin
		cram_we    = 1'b0;
		cram_waddr = {cur_row_q, cur_col_q};
		cram_wdata = '{visited: 1'b0, walls: 4'hF};
		cram_raddr = {cur_row_q, cur_col_q};
		case (state_q)
			ST_IDLE: begin
				cram_raddr = {q_row, q_col};
			end
			ST_CLEAR: begin
				cram_we    = 1'b1;
				cram_waddr = clr_q;
				cram_wdata = '{visited: (clr_q == '0), walls: 4'hF};
			end
			ST_NB: begin
				if (nb_idx_q < NB_CUR) begin
					cram_raddr = {nb_row, nb_col};
				end
			end
			ST_WR_CUR: begin
				cram_we    = 1'b1;
				cram_wdata = '{visited: ent_q[4].visited, walls: ent_q[4].walls & ~dir_mask(d_q)};
			end
			ST_WR_NX: begin
				cram_we    = 1'b1;
				cram_waddr = {nb_row, nb_col};
				cram_wdata = '{visited: 1'b1,
				               walls: nx_walls_q & ~dir_mask(dir_opposite(d_q))};
			end
			default: begin
				cram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		sram_we    = 1'b0;
		sram_waddr = depth_q[ADDR_W-1:0];
		sram_wdata = {nb_row, nb_col};
		sram_raddr = depth_m1[ADDR_W-1:0];
		if (accept && request.command == CMD_START) begin
			sram_we    = 1'b1;
			sram_waddr = '0;
			sram_wdata = '0;
		end else if (state_q == ST_WR_NX && depth_q < SDEP_W'(NCELLS)) begin
			sram_we = 1'b1;
		end
	end

	// Pick the k-th open neighbor in top, right, bottom, left order.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cand[i] = inrange_q[i] && !ent_q[i].visited;
		end
		cand_cnt = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
		prod     = 35'(rnd_q) * 35'(cand_cnt);
		pick_k   = prod[33:32];
		sel_dir  = DIR_TOP;
		seen     = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i]) begin
				if (seen == {1'b0, pick_k}) begin
					sel_dir = 2'(i);
				end
				seen = seen + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			maze_rows_q <= DIM_RESET;
			maze_cols_q <= DIM_RESET;
			gen_rows_q  <= '0;
			gen_cols_q  <= '0;
			depth_q     <= '0;
			ready_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: maze_rows_q <= cfg_data;
					REG_COLS: maze_cols_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.command)
							CMD_START: begin
								if (eff_rows == '0 || eff_cols == '0) begin
									res_valid_q <= 1'b1;
								end else begin
									gen_rows_q <= eff_rows;
									gen_cols_q <= eff_cols;
									ready_q    <= 1'b0;
									depth_q    <= SDEP_W'(1);
									state_q    <= ST_CLEAR;
								end
							end
							CMD_STEP: begin
								state_q <= ST_POP_RD;
							end
							CMD_QUERY: begin
								if (query_ok) begin
									state_q <= ST_QRY_WT;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					if (clr_q == '1) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_POP_RD: begin
					if (depth_q == '0) begin
						if (gen_rows_q != '0) begin
							ready_q <= 1'b1;
						end
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_POP_WT;
					end
				end
				ST_POP_WT: begin
					state_q <= ST_NB;
				end
				ST_NB: begin
					if (nb_idx_q == NB_LAST) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (cand_cnt == '0) begin
						// Dead end: drop it and look at the cell below it.
						depth_q <= depth_m1;
						state_q <= ST_POP_RD;
					end else begin
						state_q <= ST_WR_CUR;
					end
				end
				ST_WR_CUR: begin
					state_q <= ST_WR_NX;
				end
				ST_WR_NX: begin
					if (depth_q < SDEP_W'(NCELLS)) begin
						depth_q <= depth_q + 1'b1;
					end
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_QRY_WT: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				clr_q  <= '0;
				rnd_q  <= request.random_word;
				qdir_q <= request.query_dir;
				case (request.command)
					CMD_START: res_q <= '{
						result_kind: (eff_rows == '0 || eff_cols == '0) ? KIND_DONE : KIND_STARTED,
						cell_row: '0, cell_col: '0, carved_dir: '0, wall_present: 1'b0};
					CMD_QUERY: res_q <= '{result_kind: KIND_WALL, cell_row: '0, cell_col: '0,
					                      carved_dir: '0, wall_present: 1'b1};
					default: res_q <= '{result_kind: KIND_DONE, cell_row: '0, cell_col: '0,
					                    carved_dir: '0, wall_present: 1'b0};
				endcase
			end
			ST_CLEAR: begin
				clr_q <= clr_q + 1'b1;
				res_q <= '{result_kind: KIND_STARTED, cell_row: '0, cell_col: '0,
				           carved_dir: '0, wall_present: 1'b0};
			end
			ST_POP_RD: begin
				nb_idx_q <= '0;
				res_q    <= '{result_kind: KIND_DONE, cell_row: '0, cell_col: '0,
				              carved_dir: '0, wall_present: 1'b0};
			end
			ST_POP_WT: begin
				cur_row_q <= sram_rdata[ADDR_W-1:COL_W];
				cur_col_q <= sram_rdata[COL_W-1:0];
			end
			ST_NB: begin
				if (nb_idx_q < NB_CUR) begin
					inrange_q[nb_idx_q[1:0]] <= nb_ok;
				end
				if (nb_idx_q != '0) begin
					ent_q[nb_idx_q - 3'd1] <= cram_rent;
				end
				nb_idx_q <= nb_idx_q + 1'b1;
			end
			ST_PICK: begin
				d_q        <= sel_dir;
				nx_walls_q <= ent_q[{1'b0, sel_dir}].walls;
			end
			ST_WR_CUR: begin
				res_q <= '{result_kind: KIND_CARVED, cell_row: row_ext[4:0],
				           cell_col: col_ext[4:0], carved_dir: d_q, wall_present: 1'b0};
			end
			ST_QRY_WT: begin
				res_q <= '{result_kind: KIND_WALL, cell_row: '0, cell_col: '0,
				           carved_dir: '0, wall_present: cram_rent.walls[qdir_q]};
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the randomized depth-first maze carver unit.
`timescale 1ns / 1ps
module testbench;
	import rdfs_mc_pkg::*;

	localparam int MAZE_DIM = 32;
	localparam int CELLS = MAZE_DIM * MAZE_DIM;
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam int ITEM_TARGET = 525;
	localparam int PEND_DEPTH = 16;
	localparam int DIRECTED_MAX = 48;

	typedef struct {
		bit                    reg_write;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		request_t              req;
		bit                    pinned;
		result_t               want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	request_t              request;
	logic                  result_valid;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predicted copy of the carver's state.
	logic [3:0]            wall_mem [CELLS];
	bit                    seen_mem [CELLS];
	int                    path_stack [CELLS];
	int                    path_depth;
	bit                    maze_done;
	int                    lat_rows;
	int                    lat_cols;
	logic [CFG_DATA_W-1:0] reg_rows;
	logic [CFG_DATA_W-1:0] reg_cols;

	result_t               pending_results [PEND_DEPTH];
	int                    pend_head;
	int                    pend_tail;
	stim_row_t             directed [DIRECTED_MAX];
	int                    directed_cnt;
	int                    fault_count;
	int                    items_sent;
	int                    burst_left;

	random_dfs_maze_carver_unit #(
		.MAX_ROWS(MAZE_DIM),
		.MAX_COLS(MAZE_DIM)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int eff_size(logic [CFG_DATA_W-1:0] v);
		return (v > 6'd32) ? MAZE_DIM : int'(v);
	endfunction

	function automatic void queue_result(result_t r);
		pending_results[pend_tail % PEND_DEPTH] = r;
		pend_tail++;
	endfunction

	function automatic void add_row(stim_row_t row);
		directed[directed_cnt] = row;
		directed_cnt++;
	endfunction

	function automatic result_t predict_maze_result(request_t req);
		result_t    res;
		int         rows, cols, cur, r, c, n, k, nx, cell_idx;
		int         cand [4];
		logic [1:0] dirs [4];
		logic [1:0] d, back_dir;
		logic [63:0] prod;
		bit         carved, ready;
		res = '0;
		case (req.command)
			CMD_START: begin
				rows = eff_size(reg_rows);
				cols = eff_size(reg_cols);
				if (rows == 0 || cols == 0) begin
					res.result_kind = KIND_DONE;
				end else begin
					for (int i = 0; i < CELLS; i++) begin
						wall_mem[i] = 4'hF;
						seen_mem[i] = 1'b0;
					end
					lat_rows = rows;
					lat_cols = cols;
					maze_done = 1'b0;
					seen_mem[0] = 1'b1;
					path_stack[0] = 0;
					path_depth = 1;
					res.result_kind = KIND_STARTED;
				end
			end
			CMD_STEP: begin
				carved = 1'b0;
				// Backtrack over dead ends until some cell on the path can grow.
				while (path_depth > 0 && !carved) begin
					cur = path_stack[path_depth - 1];
					r = cur / MAZE_DIM;
					c = cur % MAZE_DIM;
					n = 0;
					if (r > 0 && !seen_mem[cur - MAZE_DIM]) begin
						cand[n] = cur - MAZE_DIM;
						dirs[n] = DIR_TOP;
						n++;
					end
					if (c + 1 < lat_cols && !seen_mem[cur + 1]) begin
						cand[n] = cur + 1;
						dirs[n] = DIR_RIGHT;
						n++;
					end
					if (r + 1 < lat_rows && !seen_mem[cur + MAZE_DIM]) begin
						cand[n] = cur + MAZE_DIM;
						dirs[n] = DIR_BOTTOM;
						n++;
					end
					if (c > 0 && !seen_mem[cur - 1]) begin
						cand[n] = cur - 1;
						dirs[n] = DIR_LEFT;
						n++;
					end
					if (n == 0) begin
						path_depth--;
					end else begin
						prod = 64'(req.random_word) * 64'(n);
						k = int'(prod >> 32);
						nx = cand[k];
						d = dirs[k];
						back_dir = d + 2'd2;
						wall_mem[cur][d] = 1'b0;
						wall_mem[nx][back_dir] = 1'b0;
						seen_mem[nx] = 1'b1;
						if (path_depth < CELLS) begin
							path_stack[path_depth] = nx;
							path_depth++;
						end
						res.result_kind = KIND_CARVED;
						res.cell_row = 5'(r);
						res.cell_col = 5'(c);
						res.carved_dir = d;
						carved = 1'b1;
					end
				end
				if (!carved) begin
					if (lat_rows != 0) maze_done = 1'b1;
					res.result_kind = KIND_DONE;
				end
			end
			CMD_QUERY: begin
				res.result_kind = KIND_WALL;
				res.wall_present = 1'b1;
				ready = maze_done && lat_cols != 0 && lat_rows == eff_size(reg_rows);
				if (ready && int'(req.query_row) < lat_rows && int'(req.query_col) < lat_cols)
				begin
					cell_idx = int'(req.query_row) * MAZE_DIM + int'(req.query_col);
					res.wall_present = wall_mem[cell_idx][req.query_dir];
				end
			end
			default: res = '0;
		endcase
		return res;
	endfunction

	function automatic request_t random_request();
		request_t q;
		q.command = 2'($urandom);
		q.random_word = $urandom;
		q.query_row = 5'($urandom);
		q.query_col = 5'($urandom);
		q.query_dir = 2'($urandom);
		return q;
	endfunction

	// Most queries land inside the current maze or one cell past its edge.
	function automatic request_t query_request();
		request_t q;
		int row_top, col_top;
		q = random_request();
		q.command = CMD_QUERY;
		row_top = (lat_rows > 31) ? 31 : lat_rows;
		col_top = (lat_cols > 31) ? 31 : lat_cols;
		if ($urandom_range(0, 3) != 0) begin
			q.query_row = 5'($urandom_range(0, row_top));
			q.query_col = 5'($urandom_range(0, col_top));
		end
		return q;
	endfunction

	function automatic stim_row_t cmd_row(logic [1:0] cmd, logic [31:0] rnd, int qr, int qc,
			logic [1:0] qd);
		stim_row_t row;
		row.reg_write = 1'b0;
		row.reg_index = '0;
		row.reg_value = '0;
		row.req.command = cmd;
		row.req.random_word = rnd;
		row.req.query_row = 5'(qr);
		row.req.query_col = 5'(qc);
		row.req.query_dir = qd;
		row.pinned = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		stim_row_t row;
		row = cmd_row(CMD_IGNORED, '0, 0, 0, DIR_TOP);
		row.reg_write = 1'b1;
		row.reg_index = idx;
		row.reg_value = v;
		return row;
	endfunction

	function automatic stim_row_t pin(stim_row_t row, logic [1:0] kind, logic wall);
		row.pinned = 1'b1;
		row.want = '0;
		row.want.result_kind = kind;
		row.want.wall_present = wall;
		return row;
	endfunction

	function automatic stim_row_t pin_carve(stim_row_t row, int r, int c, logic [1:0] d);
		row.pinned = 1'b1;
		row.want = '0;
		row.want.result_kind = KIND_CARVED;
		row.want.cell_row = 5'(r);
		row.want.cell_col = 5'(c);
		row.want.carved_dir = d;
		return row;
	endfunction

	task automatic hold_low(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			request <= random_request();
		end
	endtask

	task automatic sender_gap();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) hold_low($urandom_range(1, 30));
		end
		burst_left--;
	endtask

	task automatic issue(input request_t req, input bit pinned, input result_t pin_val,
			output result_t predicted);
		@(negedge clk);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		predicted = predict_maze_result(req);
		items_sent++;
		if (req.command != CMD_IGNORED)
			queue_result(pinned ? pin_val : predicted);
	endtask

	task automatic send_random(input logic [1:0] cmd, output result_t predicted);
		request_t req;
		if (cmd == CMD_QUERY) begin
			req = query_request();
		end else begin
			req = random_request();
			req.command = cmd;
			if (cmd == CMD_STEP && $urandom_range(0, 9) == 0)
				req.random_word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		end
		sender_gap();
		issue(req, 1'b0, '0, predicted);
	endtask

	// Registers may only change once the block has drained; an ignored command
	// leaves nothing to wait for, so extra idle cycles follow once results have drained.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pend_head != pend_tail || busy) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS) reg_rows = v;
		else reg_cols = v;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid) begin
			if (pend_head == pend_tail) begin
				if (fault_count < 10)
					$display("unexpected result: kind=%0d row=%0d col=%0d dir=%0d wall=%0d",
						result.result_kind, result.cell_row, result.cell_col,
						result.carved_dir, result.wall_present);
				fault_count++;
			end else begin
				want = pending_results[pend_head % PEND_DEPTH];
				pend_head++;
				if (result.result_kind !== want.result_kind ||
						result.cell_row !== want.cell_row ||
						result.cell_col !== want.cell_col ||
						result.carved_dir !== want.carved_dir ||
						result.wall_present !== want.wall_present) begin
					if (fault_count < 10)
						$display({"mismatch: expected kind=%0d row=%0d col=%0d dir=%0d wall=%0d",
							" got kind=%0d row=%0d col=%0d dir=%0d wall=%0d"},
							want.result_kind, want.cell_row, want.cell_col,
							want.carved_dir, want.wall_present,
							result.result_kind, result.cell_row, result.cell_col,
							result.carved_dir, result.wall_present);
					fault_count++;
				end
			end
		end
	end

	// Generous bound on run time.
	initial begin
		#100_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : stimulus
		result_t   got;
		int        sel, rr, cc, cap, steps, cells, roll;
		bit        quit;

		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < CELLS; i++) begin
			wall_mem[i] = 4'hF;
			seen_mem[i] = 1'b0;
			path_stack[i] = 0;
		end
		path_depth = 0;
		maze_done = 1'b0;
		lat_rows = 0;
		lat_cols = 0;
		reg_rows = DIM_RESET;
		reg_cols = DIM_RESET;
		pend_head = 0;
		pend_tail = 0;
		directed_cnt = 0;
		fault_count = 0;
		items_sent = 0;
		burst_left = 0;

		// Nothing generated yet: walls read as present and steps report done.
		add_row(pin(cmd_row(CMD_QUERY, '0, 0, 0, DIR_TOP), KIND_WALL, 1'b1));
		add_row(pin(cmd_row(CMD_STEP, '0, 0, 0, DIR_TOP), KIND_DONE, 1'b0));
		add_row(cmd_row(CMD_IGNORED, 32'hFFFF_FFFF, 31, 31, DIR_LEFT));
		add_row(pin(cmd_row(CMD_QUERY, '1, 31, 31, DIR_LEFT), KIND_WALL, 1'b1));
		// A zero-sized maze cannot start.
		add_row(reg_row(REG_ROWS, 6'd0));
		add_row(pin(cmd_row(CMD_START, '0, 0, 0, DIR_TOP), KIND_DONE, 1'b0));
		add_row(pin(cmd_row(CMD_STEP, '1, 0, 0, DIR_TOP), KIND_DONE, 1'b0));
		// Oversized row count saturates; a single column only grows downward.
		add_row(reg_row(REG_ROWS, 6'd63));
		add_row(reg_row(REG_COLS, 6'd1));
		add_row(pin(cmd_row(CMD_START, '0, 0, 0, DIR_TOP), KIND_STARTED, 1'b0));
		add_row(pin_carve(cmd_row(CMD_STEP, '1, 0, 0, DIR_TOP), 0, 0, DIR_BOTTOM));
		add_row(cmd_row(CMD_STEP, '0, 0, 0, DIR_TOP));
		add_row(pin(cmd_row(CMD_QUERY, '0, 0, 0, DIR_BOTTOM), KIND_WALL, 1'b1));
		// Full 2x2 maze, then queries inside and outside it.
		add_row(reg_row(REG_ROWS, 6'd2));
		add_row(reg_row(REG_COLS, 6'd2));
		add_row(pin(cmd_row(CMD_START, '1, 0, 0, DIR_TOP), KIND_STARTED, 1'b0));
		add_row(pin_carve(cmd_row(CMD_STEP, '0, 0, 0, DIR_TOP), 0, 0, DIR_RIGHT));
		add_row(cmd_row(CMD_STEP, '1, 0, 0, DIR_TOP));
		add_row(cmd_row(CMD_STEP, 32'h8000_0000, 0, 0, DIR_TOP));
		add_row(cmd_row(CMD_STEP, '0, 0, 0, DIR_TOP));
		add_row(pin(cmd_row(CMD_STEP, '1, 0, 0, DIR_TOP), KIND_DONE, 1'b0));
		add_row(cmd_row(CMD_QUERY, '0, 0, 0, DIR_RIGHT));
		add_row(cmd_row(CMD_QUERY, '1, 1, 0, DIR_TOP));
		add_row(pin(cmd_row(CMD_QUERY, '0, 31, 0, DIR_TOP), KIND_WALL, 1'b1));
		add_row(pin(cmd_row(CMD_QUERY, '0, 0, 31, DIR_BOTTOM), KIND_WALL, 1'b1));
		// Row count no longer matches the generated maze, so it is not ready.
		add_row(reg_row(REG_ROWS, 6'd1));
		add_row(pin(cmd_row(CMD_QUERY, '0, 0, 0, DIR_RIGHT), KIND_WALL, 1'b1));
		// A column change alone does not hide the maze.
		add_row(reg_row(REG_ROWS, 6'd2));
		add_row(reg_row(REG_COLS, 6'd32));
		add_row(cmd_row(CMD_QUERY, '0, 1, 1, DIR_LEFT));
		// A single cell has nowhere to go.
		add_row(reg_row(REG_ROWS, 6'd1));
		add_row(reg_row(REG_COLS, 6'd1));
		add_row(pin(cmd_row(CMD_START, '0, 0, 0, DIR_TOP), KIND_STARTED, 1'b0));
		add_row(pin(cmd_row(CMD_STEP, '0, 0, 0, DIR_TOP), KIND_DONE, 1'b0));
		add_row(pin(cmd_row(CMD_QUERY, '0, 0, 0, DIR_LEFT), KIND_WALL, 1'b1));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		for (int i = 0; i < directed_cnt; i++) begin
			if (directed[i].reg_write) begin
				settle();
				write_reg(directed[i].reg_index, directed[i].reg_value);
			end else begin
				issue(directed[i].req, directed[i].pinned, directed[i].want, got);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				rr = $urandom_range(1, 6);
				cc = $urandom_range(1, 6);
			end else if (sel < 72) begin
				rr = $urandom_range(1, 3);
				cc = $urandom_range(7, 32);
			end else if (sel < 84) begin
				rr = $urandom_range(7, 32);
				cc = $urandom_range(1, 3);
			end else if (sel < 89) begin
				rr = $urandom_range(32, 63);
				cc = $urandom_range(32, 63);
			end else if (sel < 95) begin
				rr = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
				cc = (rr == 0) ? $urandom_range(0, 63) : 0;
			end else begin
				rr = $urandom_range(33, 63);
				cc = $urandom_range(1, 4);
			end
			settle();
			if ($urandom_range(0, 9) != 0) write_reg(REG_ROWS, 6'(rr));
			if ($urandom_range(0, 9) != 0) write_reg(REG_COLS, 6'(cc));

			// Probe the previous maze under the new setting before restarting.
			if ($urandom_range(0, 9) < 4)
				repeat ($urandom_range(1, 3)) send_random(CMD_QUERY, got);

			send_random(CMD_START, got);
			cells = eff_size(reg_rows) * eff_size(reg_cols);
			cap = (cells > 150) ? 40 : 200;
			steps = 0;
			quit = 1'b0;
			while (steps < cap && !quit) begin
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					send_random(CMD_QUERY, got);
				end else if (roll < 14) begin
					send_random(CMD_IGNORED, got);
				end else if (roll < 15) begin
					send_random(CMD_START, got);
				end else if (roll < 16) begin
					quit = 1'b1;
				end else begin
					send_random(CMD_STEP, got);
					steps++;
					if (got.result_kind == KIND_DONE) quit = 1'b1;
				end
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2)) send_random(CMD_STEP, got);
			repeat ($urandom_range(3, 15)) send_random(CMD_QUERY, got);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pend_head != pend_tail) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
